// ===== hw/rtl/tsfp_pkg.sv =====
// tsfp_pkg: shared types and constants for the tftp-style frame parser
// parse phases, result kinds, opcodes and the result record
// no dependencies
package tsfp_pkg;

   // largest data payload accepted, larger frames are dropped
   localparam logic [15:0] MAX_PAYLOAD = 16'd512;

   // frame opcodes
   localparam logic [15:0] OP_DATA  = 16'd3;
   localparam logic [15:0] OP_ACK   = 16'd4;
   localparam logic [15:0] OP_ERROR = 16'd5;
   localparam logic [15:0] OP_BCAST = 16'd9;

   typedef enum logic [3:0] {
      PH_OPH   = 4'd0,
      PH_OPL   = 4'd1,
      PH_DSH   = 4'd2,
      PH_DSL   = 4'd3,
      PH_DBH   = 4'd4,
      PH_DBL   = 4'd5,
      PH_DPAY  = 4'd6,
      PH_DSKIP = 4'd7,
      PH_ACKH  = 4'd8,
      PH_ACKL  = 4'd9,
      PH_ERH   = 4'd10,
      PH_ERL   = 4'd11,
      PH_ERT   = 4'd12,
      PH_BFLAG = 4'd13,
      PH_BNAME = 4'd14
   } phase_type;

   typedef enum logic [3:0] {
      KIND_DATA_HDR   = 4'd0,
      KIND_DATA_BYTE  = 4'd1,
      KIND_ACK        = 4'd2,
      KIND_ERR_HDR    = 4'd3,
      KIND_ERR_CHAR   = 4'd4,
      KIND_BCAST_HDR  = 4'd5,
      KIND_NAME_CHAR  = 4'd6,
      KIND_UNKNOWN_OP = 4'd7,
      KIND_OVERSIZE   = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [15:0] block_number;
      logic [15:0] payload_size;
      logic [15:0] error_code;
      logic        added;
      logic [15:0] opcode_seen;
      logic        last;
   } result_type;

endpackage

// ===== hw/rtl/tftp_style_frame_parser.sv =====
// tftp_style_frame_parser: streaming parser for tftp-style frames
// each result is registered in the output register that drives rsp_, or in the skid while rsp_ stalls
// throughput: one byte per cycle while req_stall is low, set by the phase update
// a two-deep result stage (output register plus skid) keeps req_ open while a result waits
// reset (synchronous, active high) returns to waiting for an opcode and empties the results
// uses tsfp_pkg
module tftp_style_frame_parser
   import tsfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_block_number,
   output logic [15:0] rsp_payload_size,
   output logic [15:0] rsp_error_code,
   output logic        rsp_added,
   output logic [15:0] rsp_opcode_seen,
   output logic        rsp_last
);

   // parser state
   phase_type   phase_ff, phase_in;
   logic [15:0] opcode_ff, opcode_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] field_ff, field_in;   // block number, error code or added flag
   logic [15:0] size_ff, size_in;
   logic [15:0] count_ff, count_in;

   // result stage
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;

   logic        req_accept;
   logic        rsp_take;
   logic [15:0] word;
   logic [15:0] count_inc;
   result_type  res;
   logic        res_fire;

   // the skid entry only fills while the output is stalled, so stall input on it
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   // 16-bit field assembled from the held high byte and the current byte
   assign word      = {hold_ff, req_in_byte};
   assign count_inc = count_ff + 16'd1;

   // phase update and result formation for one byte transfer
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      hold_in   = hold_ff;
      field_in  = field_ff;
      size_in   = size_ff;
      count_in  = count_ff;
      res       = '0;
      res_fire  = 1'b0;
      if (req_accept) begin
         unique case (phase_ff)
            PH_OPL: begin
               opcode_in = word;
               count_in  = '0;
               if (word == OP_DATA) begin
                  phase_in = PH_DSH;
               end else if (word == OP_ACK) begin
                  phase_in = PH_ACKH;
               end else if (word == OP_ERROR) begin
                  phase_in = PH_ERH;
               end else if (word == OP_BCAST) begin
                  phase_in = PH_BFLAG;
               end else begin
                  // unknown opcode: report it and resync on the next byte
                  phase_in = PH_OPH;
                  res_fire = 1'b1;
                  res.kind = KIND_UNKNOWN_OP;
                  res.last = 1'b1;
               end
            end
            PH_DSH: begin
               hold_in  = req_in_byte;
               phase_in = PH_DSL;
            end
            PH_DBH: begin
               hold_in  = req_in_byte;
               phase_in = PH_DBL;
            end
            PH_ACKH: begin
               hold_in  = req_in_byte;
               phase_in = PH_ACKL;
            end
            PH_ERH: begin
               hold_in  = req_in_byte;
               phase_in = PH_ERL;
            end
            PH_DSL: begin
               size_in  = word;
               phase_in = PH_DBH;
            end
            PH_DBL: begin
               field_in           = word;
               count_in           = '0;
               res_fire           = 1'b1;
               res.block_number   = word;
               res.payload_size   = size_ff;
               if (size_ff > MAX_PAYLOAD) begin
                  // oversize: flag it and swallow the payload
                  phase_in = PH_DSKIP;
                  res.kind = KIND_OVERSIZE;
                  res.last = 1'b1;
               end else if (size_ff == '0) begin
                  // empty data frame ends with its header
                  phase_in = PH_OPH;
                  res.kind = KIND_DATA_HDR;
                  res.last = 1'b1;
               end else begin
                  phase_in = PH_DPAY;
                  res.kind = KIND_DATA_HDR;
               end
            end
            PH_DPAY: begin
               count_in         = count_inc;
               res_fire         = 1'b1;
               res.kind         = KIND_DATA_BYTE;
               res.byte_value   = req_in_byte;
               res.block_number = field_ff;
               res.payload_size = size_ff;
               if (count_inc == size_ff) begin
                  phase_in = PH_OPH;
                  res.last = 1'b1;
               end
            end
            PH_DSKIP: begin
               count_in = count_inc;
               if (count_inc == size_ff) begin
                  phase_in = PH_OPH;
               end
            end
            PH_ACKL: begin
               field_in         = word;
               phase_in         = PH_OPH;
               res_fire         = 1'b1;
               res.kind         = KIND_ACK;
               res.block_number = word;
               res.last         = 1'b1;
            end
            PH_ERL: begin
               field_in       = word;
               phase_in       = PH_ERT;
               res_fire       = 1'b1;
               res.kind       = KIND_ERR_HDR;
               res.error_code = word;
            end
            PH_ERT: begin
               res_fire       = 1'b1;
               res.kind       = KIND_ERR_CHAR;
               res.error_code = field_ff;
               res.byte_value = req_in_byte;
               if (req_in_byte == 8'd0) begin
                  phase_in = PH_OPH;
                  res.last = 1'b1;
               end
            end
            PH_BFLAG: begin
               // any nonzero flag byte means added
               field_in  = {15'd0, (req_in_byte != 8'd0)};
               phase_in  = PH_BNAME;
               res_fire  = 1'b1;
               res.kind  = KIND_BCAST_HDR;
               res.added = (req_in_byte != 8'd0);
            end
            PH_BNAME: begin
               res_fire       = 1'b1;
               res.kind       = KIND_NAME_CHAR;
               res.added      = field_ff[0];
               res.byte_value = req_in_byte;
               if (req_in_byte == 8'd0) begin
                  phase_in = PH_OPH;
                  res.last = 1'b1;
               end
            end
            default: begin
               // opcode high byte, also any unused phase code
               hold_in  = req_in_byte;
               phase_in = PH_OPL;
            end
         endcase
      end
      res.opcode_seen = opcode_in;
   end

   // result stage: output register with a one-entry skid behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_fire;
         end
      end else if (res_fire) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_OPH;
         opcode_ff     <= '0;
         hold_ff       <= '0;
         field_ff      <= '0;
         size_ff       <= '0;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         opcode_ff     <= opcode_in;
         hold_ff       <= hold_in;
         field_ff      <= field_in;
         size_ff       <= size_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_byte_value   = out_ff.byte_value;
   assign rsp_block_number = out_ff.block_number;
   assign rsp_payload_size = out_ff.payload_size;
   assign rsp_error_code   = out_ff.error_code;
   assign rsp_added        = out_ff.added;
   assign rsp_opcode_seen  = out_ff.opcode_seen;
   assign rsp_last         = out_ff.last;

   // skid entry is only ever occupied behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   // a payload count stays below the declared size until the frame ends
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DPAY || phase_ff == PH_DSKIP) |-> (count_ff < size_ff))
      else $error("payload count reached declared size without ending frame");

   // payload streaming only for sizes within the limit
   a_pay_size_ok: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DPAY) |-> (size_ff != '0 && size_ff <= MAX_PAYLOAD))
      else $error("payload phase with empty or oversize frame");

   // a result formed while the output is stalled must land in the skid
   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (res_fire && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("result lost while output stalled");

endmodule

// ===== bench/frame_scoreboard_pkg.sv =====
// frame_scoreboard_pkg: scoreboard class for the tftp-style frame parser bench
// follows the parse state for every accepted byte and checks results in order
// depends on tsfp_pkg
package frame_scoreboard_pkg;
   import tsfp_pkg::*;

   class frame_scoreboard;
      phase_type   phase;
      logic [15:0] opcode;
      logic [7:0]  hold;
      logic [15:0] header;
      logic [15:0] size;
      logic [15:0] count;
      result_type  pending_results[$];
      int          errors;
      int          checked;

      function new();
         phase   = PH_OPH;
         opcode  = '0;
         hold    = '0;
         header  = '0;
         size    = '0;
         count   = '0;
         errors  = 0;
         checked = 0;
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         if (errors < 30) begin
            $display("mismatch at result %0d, %s: got %0h, want %0h", checked, what, got, want);
         end
         errors++;
      endtask

      // advance the parse state by one byte, queue the result it gives, if any
      function void note_byte(logic [7:0] b);
         logic [15:0] word;
         result_type  r;
         bit          gives;
         word  = {hold, b};
         r     = '0;
         gives = 1'b1;
         case (phase)
            PH_OPL: begin
               opcode = word;
               count  = '0;
               gives  = 1'b0;
               if (word == OP_DATA) begin
                  phase = PH_DSH;
               end else if (word == OP_ACK) begin
                  phase = PH_ACKH;
               end else if (word == OP_ERROR) begin
                  phase = PH_ERH;
               end else if (word == OP_BCAST) begin
                  phase = PH_BFLAG;
               end else begin
                  phase  = PH_OPH;
                  gives  = 1'b1;
                  r.kind = KIND_UNKNOWN_OP;
                  r.last = 1'b1;
               end
            end
            PH_DSH, PH_DBH, PH_ACKH, PH_ERH: begin
               hold  = b;
               phase = phase_type'(phase + 4'd1);
               gives = 1'b0;
            end
            PH_DSL: begin
               size  = word;
               phase = PH_DBH;
               gives = 1'b0;
            end
            PH_DBL: begin
               header         = word;
               count          = '0;
               r.block_number = word;
               r.payload_size = size;
               if (size > MAX_PAYLOAD) begin
                  phase  = PH_DSKIP;
                  r.kind = KIND_OVERSIZE;
                  r.last = 1'b1;
               end else if (size == 16'd0) begin
                  phase  = PH_OPH;
                  r.kind = KIND_DATA_HDR;
                  r.last = 1'b1;
               end else begin
                  phase  = PH_DPAY;
                  r.kind = KIND_DATA_HDR;
               end
            end
            PH_DPAY: begin
               count          = count + 16'd1;
               r.kind         = KIND_DATA_BYTE;
               r.byte_value   = b;
               r.block_number = header;
               r.payload_size = size;
               if (count == size) begin
                  phase  = PH_OPH;
                  r.last = 1'b1;
               end
            end
            PH_DSKIP: begin
               count = count + 16'd1;
               gives = 1'b0;
               if (count == size) begin
                  phase = PH_OPH;
               end
            end
            PH_ACKL: begin
               header         = word;
               phase          = PH_OPH;
               r.kind         = KIND_ACK;
               r.block_number = word;
               r.last         = 1'b1;
            end
            PH_ERL: begin
               header       = word;
               phase        = PH_ERT;
               r.kind       = KIND_ERR_HDR;
               r.error_code = word;
            end
            PH_ERT: begin
               r.kind       = KIND_ERR_CHAR;
               r.byte_value = b;
               r.error_code = header;
               if (b == 8'd0) begin
                  phase  = PH_OPH;
                  r.last = 1'b1;
               end
            end
            PH_BFLAG: begin
               header  = (b != 8'd0) ? 16'd1 : 16'd0;
               phase   = PH_BNAME;
               r.kind  = KIND_BCAST_HDR;
               r.added = header[0];
            end
            PH_BNAME: begin
               r.kind       = KIND_NAME_CHAR;
               r.byte_value = b;
               r.added      = header[0];
               if (b == 8'd0) begin
                  phase  = PH_OPH;
                  r.last = 1'b1;
               end
            end
            default: begin
               hold  = b;
               phase = PH_OPL;
               gives = 1'b0;
            end
         endcase
         if (gives) begin
            r.opcode_seen = opcode;
            pending_results.push_back(r);
         end
      endfunction

      task check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report("result with nothing pending, kind", 16'(got.kind), '0);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
               report("kind", 16'(got.kind), 16'(want.kind));
            if (got.byte_value !== want.byte_value)
               report("byte_value", 16'(got.byte_value), 16'(want.byte_value));
            if (got.block_number !== want.block_number)
               report("block_number", got.block_number, want.block_number);
            if (got.payload_size !== want.payload_size)
               report("payload_size", got.payload_size, want.payload_size);
            if (got.error_code !== want.error_code)
               report("error_code", got.error_code, want.error_code);
            if (got.added !== want.added)
               report("added", 16'(got.added), 16'(want.added));
            if (got.opcode_seen !== want.opcode_seen)
               report("opcode_seen", got.opcode_seen, want.opcode_seen);
            if (got.last !== want.last)
               report("last", 16'(got.last), 16'(want.last));
         end
         checked++;
      endtask
   endclass

endpackage

// ===== bench/testbench.sv =====
// testbench: self-checking bench for tftp_style_frame_parser
// streams directed, boundary, back-pressure and random frames, checks every result in order
// depends on tsfp_pkg, frame_scoreboard_pkg and the parser rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tsfp_pkg::*;
   import frame_scoreboard_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_BYTES   = 450;
   localparam int HOLD_CYCLES    = 80;     // receiver hold-off, long enough to back up the input
   localparam int SETTLE_CYCLES  = 8;      // quiet time at the end
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either channel

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_byte_value;
   logic [15:0] rsp_block_number;
   logic [15:0] rsp_payload_size;
   logic [15:0] rsp_error_code;
   logic        rsp_added;
   logic [15:0] rsp_opcode_seen;
   logic        rsp_last;

   frame_scoreboard sb = new();

   // stimulus controls for the sender and the receiver, set by the main sequence
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          hold_request = 1'b0;

   logic [7:0]  frame_bytes[$];
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          frames_cut = 0;
   int          unknown_sent = 0;

   tftp_style_frame_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_block_number (rsp_block_number),
      .rsp_payload_size (rsp_payload_size),
      .rsp_error_code   (rsp_error_code),
      .rsp_added        (rsp_added),
      .rsp_opcode_seen  (rsp_opcode_seen),
      .rsp_last         (rsp_last)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- byte sender

   // one byte transfer: optional idle cycles, then hold valid and the byte until taken
   task automatic send_byte(input logic [7:0] b);
      while (send_idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      // req_stall read here is its value at the edge just passed
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   // drop valid and wait until the parser has handed over everything owed
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- frame building

   task automatic add_word(input logic [15:0] w);
      frame_bytes.push_back(w[15:8]);
      frame_bytes.push_back(w[7:0]);
   endtask

   // payload (or skipped bytes on an oversize frame) is random over the full byte range
   task automatic build_data(input logic [15:0] size, input logic [15:0] block);
      add_word(OP_DATA);
      add_word(size);
      add_word(block);
      repeat (int'(size)) frame_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic build_ack(input logic [15:0] block);
      add_word(OP_ACK);
      add_word(block);
   endtask

   // text never holds a zero before its terminator
   task automatic build_error(input logic [15:0] code, input int len);
      add_word(OP_ERROR);
      add_word(code);
      repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
      frame_bytes.push_back(8'h00);
   endtask

   task automatic build_bcast(input logic [7:0] flag, input int len);
      add_word(OP_BCAST);
      frame_bytes.push_back(flag);
      repeat (len) frame_bytes.push_back(8'($urandom_range(1, 255)));
      frame_bytes.push_back(8'h00);
   endtask

   function automatic logic [15:0] random_bad_opcode();
      logic [15:0] op;
      op = 16'($urandom_range(65535));
      while (op == OP_DATA || op == OP_ACK || op == OP_ERROR || op == OP_BCAST)
         op = 16'($urandom_range(65535));
      return op;
   endfunction

   task automatic build_random_frame();
      case ($urandom_range(3))
         0: begin
            // mostly short payloads, now and then just over the limit
            if ($urandom_range(11) == 0)
               build_data(MAX_PAYLOAD + 16'($urandom_range(1, 8)), 16'($urandom_range(65535)));
            else
               build_data(16'($urandom_range(16)), 16'($urandom_range(65535)));
         end
         1: build_ack(16'($urandom_range(65535)));
         2: build_error(16'($urandom_range(65535)), $urandom_range(10));
         default: begin
            if ($urandom_range(3) == 0)
               build_bcast(8'h00, $urandom_range(10));
            else
               build_bcast(8'($urandom_range(1, 255)), $urandom_range(10));
         end
      endcase
   endtask

   // send the first keep bytes of the built frame, then feed zeros until the
   // parser is back at an opcode boundary (zeros close text, names and headers)
   task automatic send_frame(input int keep);
      int n;
      n = (keep < frame_bytes.size()) ? keep : frame_bytes.size();
      if (n < frame_bytes.size()) frames_cut++;
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
      frame_bytes.delete();
      frames_sent++;
      while (sb.phase != PH_OPH) send_byte(8'h00);
   endtask

   // ---------------------------------------------------------------- result receiver

   initial begin
      int         hold_left;
      result_type got;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         // sample the transfer at this edge before moving stall
         if (rsp_valid && !rsp_stall) begin
            got.kind         = kind_type'(rsp_kind);
            got.byte_value   = rsp_byte_value;
            got.block_number = rsp_block_number;
            got.payload_size = rsp_payload_size;
            got.error_code   = rsp_error_code;
            got.added        = rsp_added;
            got.opcode_seen  = rsp_opcode_seen;
            got.last         = rsp_last;
            sb.check_result(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= recv_idle_on && ($urandom_range(99) < 34);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: %0d cycles without a transfer, %0d results still owed",
               quiet, sb.pending_results.size());
      $display("testbench NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int start;
      int pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: unknown opcode zero, ack with the top block number,
      // zero-size data, error with empty text, deleted broadcast with a 0xff name byte
      add_word(16'h0000);
      send_frame(2);
      unknown_sent++;
      build_ack(16'hffff);
      send_frame(frame_bytes.size());
      build_data(16'd0, 16'h0000);
      send_frame(frame_bytes.size());
      build_error(16'hffff, 0);
      send_frame(frame_bytes.size());
      build_bcast(8'h00, 0);
      frame_bytes.insert(3, 8'hff);
      send_frame(frame_bytes.size());

      // payload size limit, largest accepted then smallest dropped, with no idling
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      build_data(MAX_PAYLOAD, 16'h8001);
      send_frame(frame_bytes.size());
      build_data(MAX_PAYLOAD + 16'd1, 16'h7ffe);
      send_frame(frame_bytes.size());
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;

      // back-pressure: the receiver holds off while a long name streams in,
      // so the result stage fills and the input stalls
      hold_request = 1'b1;
      build_bcast(8'h5a, 40);
      send_frame(frame_bytes.size());
      pause_until_drained();

      // random: mostly well-formed frames, some unknown opcodes and cut-short frames
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 82) begin
            build_random_frame();
            send_frame(frame_bytes.size());
         end else if (pick < 90) begin
            add_word(random_bad_opcode());
            send_frame(2);
            unknown_sent++;
         end else begin
            build_random_frame();
            send_frame($urandom_range(1, frame_bytes.size() - 1));
         end
      end

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d frames (%0d cut short, %0d unknown opcodes),",
               bytes_sent, frames_sent, frames_cut, unknown_sent);
      $display("payload size limit, zero-size data, back-pressure; %0d results checked",
               sb.checked);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
